[hw/rtl/tljs_pkg.sv]
package tljs_pkg;

  localparam int unsigned MaxWords = 64;

  localparam logic [1:0] MODE_WORD = 2'd0;
  localparam logic [1:0] MODE_CHAR = 2'd1;
  localparam logic [1:0] MODE_DIST = 2'd2;
  localparam logic [1:0] MODE_AUTO = 2'd3;

  typedef struct packed {
    logic        has_text;
    logic [15:0] fill_px;
    logic [15:0] meas_px;
    logic [6:0]  n_words;
    logic [11:0] n_chars;
    logic [1:0]  just_sel;
  } in_t;

  typedef struct packed {
    logic [5:0]  gap_index;
    logic [15:0] gap_space;
    logic        gap_valid;
    logic [15:0] word_adjust;
    logic [15:0] char_adjust;
    logic        char_valid;
    logic        justified;
    logic        last;
  } out_t;

  // datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_NOP,
    OP_SETUP,
    OP_LOAD_W,
    OP_LOAD_C,
    OP_DIV_STEP,
    OP_STORE_W,
    OP_STORE_C,
    OP_EMIT
  } op_e;

  // jump condition; a step jumps to its target when the condition holds
  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_START,
    CND_NO_WORD,
    CND_NO_CHAR,
    CND_DIV_MORE,
    CND_NOT_LAST
  } cond_e;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } ctrl_t;

  localparam upc_t UPC_IDLE   = 4'd0;
  localparam upc_t UPC_SETUP  = 4'd1;
  localparam upc_t UPC_WCHK   = 4'd2;
  localparam upc_t UPC_WLOAD  = 4'd3;
  localparam upc_t UPC_WDIV   = 4'd4;
  localparam upc_t UPC_WSTORE = 4'd5;
  localparam upc_t UPC_CCHK   = 4'd6;
  localparam upc_t UPC_CLOAD  = 4'd7;
  localparam upc_t UPC_CDIV   = 4'd8;
  localparam upc_t UPC_CSTORE = 4'd9;
  localparam upc_t UPC_EMIT   = 4'd10;
  localparam upc_t UPC_DONE   = 4'd11;

  // microcode store
  function automatic ctrl_t ucode(input upc_t pc);
    ctrl_t w;
    unique case (pc)
      UPC_IDLE:   w = '{op: OP_NOP,      cond: CND_NO_START, target: UPC_IDLE};
      UPC_SETUP:  w = '{op: OP_SETUP,    cond: CND_NEVER,    target: UPC_IDLE};
      UPC_WCHK:   w = '{op: OP_NOP,      cond: CND_NO_WORD,  target: UPC_CCHK};
      UPC_WLOAD:  w = '{op: OP_LOAD_W,   cond: CND_NEVER,    target: UPC_IDLE};
      UPC_WDIV:   w = '{op: OP_DIV_STEP, cond: CND_DIV_MORE, target: UPC_WDIV};
      UPC_WSTORE: w = '{op: OP_STORE_W,  cond: CND_NEVER,    target: UPC_IDLE};
      UPC_CCHK:   w = '{op: OP_NOP,      cond: CND_NO_CHAR,  target: UPC_EMIT};
      UPC_CLOAD:  w = '{op: OP_LOAD_C,   cond: CND_NEVER,    target: UPC_IDLE};
      UPC_CDIV:   w = '{op: OP_DIV_STEP, cond: CND_DIV_MORE, target: UPC_CDIV};
      UPC_CSTORE: w = '{op: OP_STORE_C,  cond: CND_NEVER,    target: UPC_IDLE};
      UPC_EMIT:   w = '{op: OP_EMIT,     cond: CND_NOT_LAST, target: UPC_EMIT};
      UPC_DONE:   w = '{op: OP_NOP,      cond: CND_ALWAYS,   target: UPC_IDLE};
      default:    w = '{op: OP_NOP,      cond: CND_ALWAYS,   target: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/text_line_justify_spacing.sv]
// Channel   Ports                      Direction  Transfer
// request   start_i, busy_o, req_i     in         start_i high and busy_o low at a clock edge
// result    valid_o, res_o             out        one cycle per result, marked by valid_o
//
// Steps: a request runs two 16-step restoring divisions, one for word gaps and one
// for character gaps, then emits one result per cycle; a skipped division omits its
// load, division and store steps. A DONE step follows the last result before idle.
// The step rate is set by the shared one-bit-per-cycle divider and the emit loop.
// Reset: rst_ni asynchronous, active low; returns the sequencer to its idle step.
// Stalls: the receiver cannot stall; results leave one per cycle back to back.
module text_line_justify_spacing (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  tljs_pkg::in_t    req_i,
  output logic             busy_o,
  output logic             valid_o,
  output tljs_pkg::out_t   res_o
);

  // sequencer
  tljs_pkg::upc_t  pc_q, pc_d;
  tljs_pkg::ctrl_t cw;
  logic            jump;
  logic            valid_q;
  logic            accept;

  // request and setup results
  tljs_pkg::in_t   req_q;
  logic [15:0]     word_extra_q, char_extra_q;
  logic            word_app_q, char_app_q, justified_q;
  logic [5:0]      gaps_q;

  // shared divider
  logic [15:0]     quo_q;
  logic [11:0]     rem_q;
  logic [11:0]     den_q;
  logic [3:0]      div_cnt_q;
  logic [12:0]     trial;
  logic            fits;

  // stored quotients and emit state
  logic [15:0]     per_gap_q, char_adj_q;
  logic [5:0]      rem_w_q;
  logic [5:0]      idx_q;
  logic [5:0]      last_idx;
  logic            is_last;
  tljs_pkg::out_t  res_q;

  // setup combinational terms
  logic [15:0]     extra;
  logic            do_just;
  logic [6:0]      words_sat;
  logic            multi;
  logic            use_w, use_c;
  logic [15:0]     we, ce;

  assign cw     = tljs_pkg::ucode(pc_q);
  assign busy_o = (pc_q != tljs_pkg::UPC_IDLE);
  assign accept = start_i && !busy_o;

  // line decision: how the shortfall splits between word and character gaps
  always_comb begin
    extra     = req_q.fill_px - req_q.meas_px;
    do_just   = req_q.has_text && (req_q.fill_px != 16'd0)
                && (req_q.meas_px < req_q.fill_px);
    words_sat = (req_q.n_words > 7'(tljs_pkg::MaxWords)) ? 7'(tljs_pkg::MaxWords)
                                                          : req_q.n_words;
    multi     = (words_sat > 7'd1);
    use_w     = 1'b0;
    use_c     = 1'b0;
    we        = '0;
    ce        = '0;
    case (req_q.just_sel)
      tljs_pkg::MODE_WORD: begin
        use_w = 1'b1;
        we    = extra;
      end
      tljs_pkg::MODE_CHAR: begin
        use_c = 1'b1;
        ce    = extra;
      end
      tljs_pkg::MODE_DIST: begin
        use_c = 1'b1;
        if (multi) begin
          use_w = 1'b1;
          we    = extra >> 1;
          ce    = extra - (extra >> 1);
        end else begin
          ce    = extra;
        end
      end
      default: begin
        if (multi) begin
          use_w = 1'b1;
          we    = extra;
        end else begin
          use_c = 1'b1;
          ce    = extra;
        end
      end
    endcase
  end

  // restoring division: shift in one dividend bit, subtract when it fits
  assign trial = {rem_q, quo_q[15]};
  assign fits  = (trial >= {1'b0, den_q});

  // final gap index is gaps-1 when word spacing applies, else the single result
  assign last_idx = word_app_q ? (gaps_q - 6'd1) : 6'd0;
  assign is_last  = (idx_q == last_idx);

  always_comb begin
    unique case (cw.cond)
      tljs_pkg::CND_NEVER:    jump = 1'b0;
      tljs_pkg::CND_ALWAYS:   jump = 1'b1;
      tljs_pkg::CND_NO_START: jump = !start_i;
      tljs_pkg::CND_NO_WORD:  jump = !word_app_q;
      tljs_pkg::CND_NO_CHAR:  jump = !char_app_q;
      tljs_pkg::CND_DIV_MORE: jump = (div_cnt_q != 4'd0);
      tljs_pkg::CND_NOT_LAST: jump = !is_last;
      default:                jump = 1'b0;
    endcase
    pc_d = jump ? cw.target : pc_q + 4'd1;
  end

  // control state: step counter and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= tljs_pkg::UPC_IDLE;
      valid_q <= 1'b0;
    end else begin
      pc_q    <= pc_d;
      valid_q <= (cw.op == tljs_pkg::OP_EMIT);
    end
  end

  // datapath driven by the control word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    unique case (cw.op)
      tljs_pkg::OP_SETUP: begin
        word_extra_q <= we;
        char_extra_q <= ce;
        word_app_q   <= do_just && use_w && multi;
        char_app_q   <= do_just && use_c && (req_q.n_chars > 12'd1);
        justified_q  <= do_just;
        gaps_q       <= 6'(words_sat - 7'd1);
        per_gap_q    <= '0;
        rem_w_q      <= '0;
        char_adj_q   <= '0;
        idx_q        <= '0;
      end
      tljs_pkg::OP_LOAD_W: begin
        quo_q     <= word_extra_q;
        rem_q     <= '0;
        den_q     <= {6'd0, gaps_q};
        div_cnt_q <= 4'd15;
      end
      tljs_pkg::OP_LOAD_C: begin
        quo_q     <= char_extra_q;
        rem_q     <= '0;
        den_q     <= req_q.n_chars - 12'd1;
        div_cnt_q <= 4'd15;
      end
      tljs_pkg::OP_DIV_STEP: begin
        rem_q     <= fits ? 12'(trial - {1'b0, den_q}) : trial[11:0];
        quo_q     <= {quo_q[14:0], fits};
        div_cnt_q <= div_cnt_q - 4'd1;
      end
      tljs_pkg::OP_STORE_W: begin
        per_gap_q <= quo_q;
        rem_w_q   <= rem_q[5:0];
      end
      tljs_pkg::OP_STORE_C: begin
        char_adj_q <= quo_q;
      end
      tljs_pkg::OP_EMIT: begin
        // remainder pixels go to the lowest-numbered gaps
        res_q.gap_index   <= word_app_q ? idx_q : 6'd0;
        res_q.gap_space   <= word_app_q ? (per_gap_q + {15'd0, (idx_q < rem_w_q)}) : 16'd0;
        res_q.gap_valid   <= word_app_q;
        res_q.word_adjust <= word_app_q ? per_gap_q : 16'd0;
        res_q.char_adjust <= char_adj_q;
        res_q.char_valid  <= char_app_q;
        res_q.justified   <= justified_q;
        res_q.last        <= is_last;
        idx_q             <= idx_q + 6'd1;
      end
      default: begin
      end
    endcase
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

`ifndef SYNTHESIS
  // results only appear while a request is in progress
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("result outside a request");

  // a non-final result is followed directly by the next one
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !res_o.last) |=> valid_o) else $error("gap in result burst");

  // nothing follows the final result
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.last) |=> !valid_o) else $error("result after last");

  // a result without word spacing is always the only one
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !res_o.gap_valid) |-> res_o.last) else $error("extra result without gaps");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;

  // One row of the directed plan: a line request, plus a hand-typed result
  // for the rows whose single result is obvious from the spec.
  typedef struct {
    tljs_pkg::in_t  line;
    bit             typed;
    tljs_pkg::out_t res;
  } plan_row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  tljs_pkg::in_t  req_i;
  logic           busy_o;
  logic           valid_o;
  tljs_pkg::out_t res_o;

  tljs_pkg::out_t gap_results_due[$];
  plan_row_t      plan[$];
  int unsigned    mismatch_count;
  int unsigned    lines_sent;
  int unsigned    results_seen;
  int unsigned    burst_left;

  text_line_justify_spacing i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop; the slowest legal run is well under a tenth of this.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Work out the gap results for one accepted line and queue them in order.
  function automatic void spread_line(input tljs_pkg::in_t ln);
    int unsigned extra, w_extra, c_extra, words, chars;
    int unsigned gaps, per_gap, rem, c_adj, n, i;
    bit use_w, use_c, just, w_app, c_app;
    tljs_pkg::out_t r;
    words   = ln.n_words;
    chars   = ln.n_chars;
    w_extra = 0;
    c_extra = 0;
    use_w   = 1'b0;
    use_c   = 1'b0;
    just    = 1'b0;
    gaps    = 0;
    per_gap = 0;
    rem     = 0;
    c_adj   = 0;
    w_app   = 1'b0;
    c_app   = 1'b0;
    // saturate oversized word counts
    if (words > tljs_pkg::MaxWords) words = tljs_pkg::MaxWords;
    if (ln.has_text && ln.fill_px != 16'd0 && ln.meas_px < ln.fill_px) begin
      extra = ln.fill_px - ln.meas_px;
      just  = 1'b1;
      case (ln.just_sel)
        tljs_pkg::MODE_WORD: begin
          use_w   = 1'b1;
          w_extra = extra;
        end
        tljs_pkg::MODE_CHAR: begin
          use_c   = 1'b1;
          c_extra = extra;
        end
        tljs_pkg::MODE_DIST: begin
          if (words > 1) begin
            use_w   = 1'b1;
            w_extra = extra / 2;
            use_c   = 1'b1;
            c_extra = extra - w_extra;
          end else begin
            use_c   = 1'b1;
            c_extra = extra;
          end
        end
        default: begin
          if (words > 1) begin
            use_w   = 1'b1;
            w_extra = extra;
          end else begin
            use_c   = 1'b1;
            c_extra = extra;
          end
        end
      endcase
    end
    if (use_w && words > 1) begin
      gaps    = words - 1;
      per_gap = w_extra / gaps;
      rem     = w_extra % gaps;
      w_app   = 1'b1;
    end
    if (use_c && chars > 1) begin
      c_adj = c_extra / (chars - 1);
      c_app = 1'b1;
    end
    n = w_app ? gaps : 1;
    for (i = 0; i < n; i++) begin
      r.gap_index   = w_app ? i[5:0] : 6'd0;
      r.gap_space   = w_app ? 16'(per_gap + ((i < rem) ? 1 : 0)) : 16'd0;
      r.gap_valid   = w_app;
      r.word_adjust = w_app ? 16'(per_gap) : 16'd0;
      r.char_adjust = 16'(c_adj);
      r.char_valid  = c_app;
      r.justified   = just;
      r.last        = (i + 1 == n);
      gap_results_due.push_back(r);
    end
  endfunction

  function automatic tljs_pkg::in_t line_of(input bit ht, input int unsigned tgt,
                                            input int unsigned wid,
                                            input int unsigned wc, input int unsigned cc,
                                            input logic [1:0] mode);
    tljs_pkg::in_t ln;
    ln.has_text = ht;
    ln.fill_px  = 16'(tgt);
    ln.meas_px  = 16'(wid);
    ln.n_words  = 7'(wc);
    ln.n_chars  = 12'(cc);
    ln.just_sel = mode;
    return ln;
  endfunction

  function automatic tljs_pkg::out_t res_of(input int unsigned idx, input int unsigned space,
                                            input bit gv,
                                            input int unsigned wadj, input int unsigned cadj,
                                            input bit cv, input bit just);
    tljs_pkg::out_t r;
    r.gap_index   = 6'(idx);
    r.gap_space   = 16'(space);
    r.gap_valid   = gv;
    r.word_adjust = 16'(wadj);
    r.char_adjust = 16'(cadj);
    r.char_valid  = cv;
    r.justified   = just;
    r.last        = 1'b1;
    return r;
  endfunction

  // Random line: mostly lines that really need justifying, with some
  // no-text, zero-target and already-full lines mixed in as noise.
  function automatic tljs_pkg::in_t rand_line();
    tljs_pkg::in_t ln;
    int unsigned pick;
    ln.has_text = ($urandom_range(0, 9) != 0);
    pick = $urandom_range(0, 9);
    if (pick == 0) ln.fill_px = 16'd0;
    else if (pick < 4) ln.fill_px = 16'($urandom_range(1, 64));
    else ln.fill_px = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) ln.meas_px = 16'($urandom);
    else if (pick == 1) ln.meas_px = ln.fill_px;
    else if (ln.fill_px != 16'd0)
      ln.meas_px = 16'($urandom_range(0, ln.fill_px - 1));
    else ln.meas_px = 16'($urandom);
    pick = $urandom_range(0, 9);
    // keep most lines short so the emit loop stays quick
    if (pick < 6) ln.n_words = 7'($urandom_range(0, 8));
    else if (pick < 9) ln.n_words = 7'($urandom_range(9, 64));
    else ln.n_words = 7'($urandom_range(65, 127));
    if ($urandom_range(0, 1) == 0) ln.n_chars = 12'($urandom_range(0, 80));
    else ln.n_chars = 12'($urandom);
    ln.just_sel = 2'($urandom);
    return ln;
  endfunction

  // Hold start low for a random gap between bursts; bursts run back to back.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(10, 40);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 6);
        gap = $urandom_range(1, 12);
      end
      if (gap != 0) begin
        @(negedge clk_i);
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Present one request and hold it until the block takes it.
  task automatic send_line(input tljs_pkg::in_t ln, input bit typed,
                           input tljs_pkg::out_t res);
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= ln;
    do @(posedge clk_i); while (busy_o);
    if (typed) gap_results_due.push_back(res);
    else spread_line(ln);
    lines_sent++;
  endtask

  // Results cannot be held off: check every strobe against the oldest entry.
  always @(posedge clk_i) begin
    tljs_pkg::out_t e;
    if (rst_ni && valid_o) begin
      results_seen++;
      if (gap_results_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %p", res_o));
      end else begin
        e = gap_results_due.pop_front();
        if (res_o.gap_index !== e.gap_index)
          flag_mismatch($sformatf("gap_index %0d, want %0d", res_o.gap_index, e.gap_index));
        if (res_o.gap_space !== e.gap_space)
          flag_mismatch($sformatf("gap_space %0d, want %0d", res_o.gap_space, e.gap_space));
        if (res_o.gap_valid !== e.gap_valid)
          flag_mismatch($sformatf("gap_valid %0b, want %0b", res_o.gap_valid, e.gap_valid));
        if (res_o.word_adjust !== e.word_adjust)
          flag_mismatch($sformatf("word_adjust %0d, want %0d", res_o.word_adjust,
                                  e.word_adjust));
        if (res_o.char_adjust !== e.char_adjust)
          flag_mismatch($sformatf("char_adjust %0d, want %0d", res_o.char_adjust,
                                  e.char_adjust));
        if (res_o.char_valid !== e.char_valid)
          flag_mismatch($sformatf("char_valid %0b, want %0b", res_o.char_valid, e.char_valid));
        if (res_o.justified !== e.justified)
          flag_mismatch($sformatf("justified %0b, want %0b", res_o.justified, e.justified));
        if (res_o.last !== e.last)
          flag_mismatch($sformatf("last %0b, want %0b", res_o.last, e.last));
      end
    end
  end

  initial begin
    tljs_pkg::out_t none;
    tljs_pkg::out_t plain;
    int unsigned k;
    none           = '0;
    none.last      = 1'b1;
    plain          = none;
    plain.justified = 1'b1;
    mismatch_count = 0;
    lines_sent     = 0;
    results_seen   = 0;
    burst_left     = 0;
    start_i        = 1'b0;
    req_i          = '0;
    rst_ni         = 1'b0;

    // Directed plan: pass-through lines, extremes of every field, each mode.
    plan.push_back('{line_of(0, 100, 10, 5, 20, tljs_pkg::MODE_WORD), 1'b1, none});
    plan.push_back('{line_of(1, 0, 0, 5, 20, tljs_pkg::MODE_WORD), 1'b1, none});
    plan.push_back('{line_of(1, 300, 300, 5, 20, tljs_pkg::MODE_DIST), 1'b1, none});
    plan.push_back('{line_of(1, 100, 65535, 5, 20, tljs_pkg::MODE_AUTO), 1'b1, none});
    plan.push_back('{line_of(1, 65535, 0, 2, 0, tljs_pkg::MODE_WORD), 1'b1,
                     res_of(0, 65535, 1, 65535, 0, 0, 1)});
    plan.push_back('{line_of(1, 1000, 0, 64, 300, tljs_pkg::MODE_WORD), 1'b0, none});
    plan.push_back('{line_of(1, 777, 3, 127, 300, tljs_pkg::MODE_WORD), 1'b0, none});
    plan.push_back('{line_of(1, 50, 10, 0, 40, tljs_pkg::MODE_WORD), 1'b1, plain});
    plan.push_back('{line_of(1, 50, 10, 1, 40, tljs_pkg::MODE_WORD), 1'b1, plain});
    plan.push_back('{line_of(1, 65535, 0, 1, 2, tljs_pkg::MODE_CHAR), 1'b1,
                     res_of(0, 0, 0, 0, 65535, 1, 1)});
    plan.push_back('{line_of(1, 80, 20, 9, 1, tljs_pkg::MODE_CHAR), 1'b1, plain});
    plan.push_back('{line_of(1, 80, 20, 9, 0, tljs_pkg::MODE_CHAR), 1'b1, plain});
    plan.push_back('{line_of(1, 65535, 0, 9, 4095, tljs_pkg::MODE_CHAR), 1'b0, none});
    plan.push_back('{line_of(1, 21, 10, 2, 2, tljs_pkg::MODE_DIST), 1'b1,
                     res_of(0, 5, 1, 5, 6, 1, 1)});
    plan.push_back('{line_of(1, 90, 10, 1, 10, tljs_pkg::MODE_DIST), 1'b0, none});
    plan.push_back('{line_of(1, 65535, 0, 64, 4095, tljs_pkg::MODE_DIST), 1'b0, none});
    plan.push_back('{line_of(1, 1, 0, 2, 3, tljs_pkg::MODE_DIST), 1'b0, none});
    plan.push_back('{line_of(1, 400, 33, 3, 1, tljs_pkg::MODE_DIST), 1'b0, none});
    plan.push_back('{line_of(1, 500, 100, 10, 60, tljs_pkg::MODE_AUTO), 1'b0, none});
    plan.push_back('{line_of(1, 500, 100, 1, 50, tljs_pkg::MODE_AUTO), 1'b0, none});
    plan.push_back('{line_of(1, 500, 100, 0, 0, tljs_pkg::MODE_AUTO), 1'b1, plain});
    plan.push_back('{line_of(1, 200, 199, 5, 30, tljs_pkg::MODE_WORD), 1'b0, none});
    plan.push_back('{line_of(1, 65535, 65534, 127, 4095, tljs_pkg::MODE_AUTO), 1'b0, none});

    // Hold reset, then release it away from the active edge.
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[k]) begin
      pace_sender();
      send_line(plan[k].line, plan[k].typed, plan[k].res);
    end

    for (k = 0; k < 320; k++) begin
      pace_sender();
      send_line(rand_line(), 1'b0, none);
    end

    // Drop start, drain the results, then watch for stragglers.
    @(negedge clk_i);
    start_i <= 1'b0;
    while (gap_results_due.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    $display("Sent %0d lines (pass-through, all four modes, saturated word counts).",
             lines_sent);
    $display("Checked %0d gap results, %0d mismatches.", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tljs_pkg.sv
hw/rtl/text_line_justify_spacing.sv
dv/tb.sv
